[rtl/core/bomm_pkg.sv]
// Shared types and constants for the boot overlay memory map unit.
// Holds address constants, operation codes and the decode bundle.
// No dependencies.
package bomm_pkg;

  localparam int unsigned BOOT_BYTES_DEF = 256;
  localparam int unsigned IO_BYTES       = 128;
  localparam int unsigned IO_AW          = $clog2(IO_BYTES);

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] byte_t;

  localparam addr_t ADDR_BOOT_END    = 16'h0100;
  localparam addr_t ADDR_BOOT_OFF    = 16'hFF50;
  localparam addr_t ADDR_LCDC        = 16'hFF40;
  localparam addr_t ADDR_STAT        = 16'hFF41;
  localparam addr_t ADDR_SCY         = 16'hFF42;
  localparam addr_t ADDR_SCX         = 16'hFF43;
  localparam addr_t ADDR_WX          = 16'hFF4B;
  localparam addr_t ADDR_WY          = 16'hFF4A;
  localparam addr_t ADDR_IE          = 16'hFFFF;
  localparam addr_t ADDR_IO_BASE     = 16'hFF00;
  localparam addr_t ADDR_IO_LAST     = 16'hFF7F;
  localparam addr_t ADDR_SERIAL_DATA = 16'hFF01;
  localparam addr_t ADDR_SERIAL_CTRL = 16'hFF02;
  localparam addr_t ADDR_DIV         = 16'hFF04;

  localparam int unsigned SERIAL_START_BIT = 7;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_BOOT,
    SRC_REG,
    SRC_IO,
    SRC_MAIN
  } src_e;

  typedef enum logic [2:0] {
    REG_LCDC,
    REG_STAT,
    REG_SCY,
    REG_SCX,
    REG_WX,
    REG_WY,
    REG_IE
  } reg_e;

  typedef struct packed {
    src_e  rd_src;
    reg_e  reg_sel;
    logic  reg_wr;
    logic  io_wr;
    byte_t io_byte;
    logic  main_wr;
    logic  boot_wr;
    logic  boot_off;
    logic  latch_wr;
    logic  serial_fire;
    logic  div_clear;
  } dec_t;

endpackage

[rtl/core/bomm_if.sv]
// Valid/ready channel interfaces for bus accesses and their results.
// Depends on bomm_pkg for the payload types.
interface bomm_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  bomm_pkg::addr_t     addr;
  bomm_pkg::byte_t     value;

  modport source (output valid, output op, output addr, output value, input ready);
  modport sink   (input valid, input op, input addr, input value, output ready);
endinterface

interface bomm_out_if;
  logic                valid;
  logic                ready;
  bomm_pkg::byte_t     read_data;
  logic                serial_valid;
  bomm_pkg::byte_t     serial_byte;
  logic                divider_clear;

  modport source (output valid, output read_data, output serial_valid,
                  output serial_byte, output divider_clear, input ready);
  modport sink   (input valid, input read_data, input serial_valid,
                  input serial_byte, input divider_clear, output ready);
endinterface

[rtl/core/boot_overlay_memory_map_unit.sv]
// Boot overlay memory map unit: bus decoder for a 16-bit address space.
//
// Channels: in_i carries one bus access per transfer (op, addr, value);
// out_o returns exactly one result per access (read_data, serial_valid,
// serial_byte, divider_clear), in order. Both use valid/ready.
//
// The decode and all writes happen at the input transfer, which also
// launches the synchronous read of boot ROM, main RAM or the I/O page into
// the read stage; the output register is loaded from the read stage when it
// advances. Throughput is one access per cycle while out_o does not stall,
// set by the single read/write port of each memory.
//
// Reset clears the display, scroll, window, interrupt-enable and serial
// registers and turns the boot overlay on. Boot ROM, main RAM and the I/O
// page hold no defined value until written.
//
// When out_o stalls, the result holds in the output register; one more
// access is taken into the read stage and then in_i.ready drops until the
// output register drains.
module boot_overlay_memory_map_unit #(
  parameter int unsigned BOOT_BYTES = bomm_pkg::BOOT_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bomm_in_if.sink     in_i,
  bomm_out_if.source  out_o
);
  import bomm_pkg::*;

  localparam int unsigned BOOT_AW = (BOOT_BYTES > 1) ? $clog2(BOOT_BYTES) : 1;

  byte_t boot_mem [BOOT_BYTES];
  byte_t main_mem [2**ADDR_W];
  byte_t io_mem   [IO_BYTES];

  dec_t  dec;
  logic  accept;
  logic  out_free;
  logic  s1_adv;

  logic  boot_en_q;
  byte_t lcdc_q, stat_q, scy_q, scx_q, wx_q, wy_q, ie_q, latch_q;
  byte_t reg_rd;

  logic  s1_valid_q;
  src_e  s1_src_q;
  byte_t s1_reg_q;
  logic  s1_serial_q;
  byte_t s1_serial_byte_q;
  logic  s1_div_q;

  byte_t boot_rdata_q, main_rdata_q, io_rdata_q;
  byte_t s1_rdata;

  logic  out_valid_q;
  byte_t out_rdata_q;
  logic  out_serial_q;
  byte_t out_serial_byte_q;
  logic  out_div_q;

  logic [BOOT_AW-1:0] boot_idx;
  logic [IO_AW-1:0]   io_idx;

  bomm_decode #(
    .BOOT_BYTES (BOOT_BYTES)
  ) u_decode (
    .op_i      (in_i.op),
    .addr_i    (in_i.addr),
    .value_i   (in_i.value),
    .boot_en_i (boot_en_q),
    .dec_o     (dec)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign accept     = in_i.valid && in_i.ready;

  assign boot_idx = in_i.addr[BOOT_AW-1:0];
  assign io_idx   = in_i.addr[IO_AW-1:0];

  always_comb begin
    unique case (dec.reg_sel)
      REG_LCDC: reg_rd = lcdc_q;
      REG_STAT: reg_rd = stat_q;
      REG_SCY:  reg_rd = scy_q;
      REG_SCX:  reg_rd = scx_q;
      REG_WX:   reg_rd = wx_q;
      REG_WY:   reg_rd = wy_q;
      REG_IE:   reg_rd = ie_q;
      default:  reg_rd = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_en_q <= 1'b1;
      lcdc_q    <= '0;
      stat_q    <= '0;
      scy_q     <= '0;
      scx_q     <= '0;
      wx_q      <= '0;
      wy_q      <= '0;
      ie_q      <= '0;
      latch_q   <= '0;
    end else if (accept) begin
      if (dec.boot_off) begin
        boot_en_q <= 1'b0;
      end
      if (dec.latch_wr) begin
        latch_q <= in_i.value;
      end
      if (dec.reg_wr) begin
        unique case (dec.reg_sel)
          REG_LCDC: lcdc_q <= in_i.value;
          REG_STAT: stat_q <= in_i.value;
          REG_SCY:  scy_q  <= in_i.value;
          REG_SCX:  scx_q  <= in_i.value;
          REG_WX:   wx_q   <= in_i.value;
          REG_WY:   wy_q   <= in_i.value;
          REG_IE:   ie_q   <= in_i.value;
          default: begin
          end
        endcase
      end
    end
  end

  // Memories: write and synchronous read at the input transfer
  always_ff @(posedge clk_i) begin
    if (accept && dec.boot_wr) begin
      boot_mem[boot_idx] <= in_i.value;
    end
    if (accept && (dec.rd_src == SRC_BOOT)) begin
      boot_rdata_q <= boot_mem[boot_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && dec.main_wr) begin
      main_mem[in_i.addr] <= in_i.value;
    end
    if (accept && (dec.rd_src == SRC_MAIN)) begin
      main_rdata_q <= main_mem[in_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && dec.io_wr) begin
      io_mem[io_idx] <= dec.io_byte;
    end
    if (accept && (dec.rd_src == SRC_IO)) begin
      io_rdata_q <= io_mem[io_idx];
    end
  end

  // Read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_src_q         <= dec.rd_src;
      s1_reg_q         <= reg_rd;
      s1_serial_q      <= dec.serial_fire;
      s1_serial_byte_q <= dec.serial_fire ? latch_q : '0;
      s1_div_q         <= dec.div_clear;
    end
  end

  always_comb begin
    unique case (s1_src_q)
      SRC_ZERO: s1_rdata = '0;
      SRC_BOOT: s1_rdata = boot_rdata_q;
      SRC_REG:  s1_rdata = s1_reg_q;
      SRC_IO:   s1_rdata = io_rdata_q;
      SRC_MAIN: s1_rdata = main_rdata_q;
      default:  s1_rdata = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_rdata_q       <= s1_rdata;
      out_serial_q      <= s1_serial_q;
      out_serial_byte_q <= s1_serial_byte_q;
      out_div_q         <= s1_div_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = out_rdata_q;
  assign out_o.serial_valid  = out_serial_q;
  assign out_o.serial_byte   = out_serial_byte_q;
  assign out_o.divider_clear = out_div_q;

endmodule

[rtl/core/bomm_decode.sv]
// Address decoder: maps one bus access to its store, register and side effects.
// Depends on bomm_pkg.
module bomm_decode #(
  parameter int unsigned BOOT_BYTES = bomm_pkg::BOOT_BYTES_DEF
) (
  input  logic [1:0]      op_i,
  input  bomm_pkg::addr_t addr_i,
  input  bomm_pkg::byte_t value_i,
  input  logic            boot_en_i,
  output bomm_pkg::dec_t  dec_o
);
  import bomm_pkg::*;

  logic boot_in_range;
  logic boot_window;
  logic is_io;
  logic reg_hit;
  reg_e reg_sel;

  assign boot_in_range = {1'b0, addr_i} < (ADDR_W+1)'(BOOT_BYTES);
  assign boot_window   = boot_en_i && (addr_i < ADDR_BOOT_END);
  assign is_io         = (addr_i >= ADDR_IO_BASE) && (addr_i <= ADDR_IO_LAST);

  always_comb begin
    reg_hit = 1'b1;
    reg_sel = REG_LCDC;
    unique case (addr_i)
      ADDR_LCDC: reg_sel = REG_LCDC;
      ADDR_STAT: reg_sel = REG_STAT;
      ADDR_SCY:  reg_sel = REG_SCY;
      ADDR_SCX:  reg_sel = REG_SCX;
      ADDR_WX:   reg_sel = REG_WX;
      ADDR_WY:   reg_sel = REG_WY;
      ADDR_IE:   reg_sel = REG_IE;
      default:   reg_hit = 1'b0;
    endcase
  end

  always_comb begin
    dec_o             = '0;
    dec_o.rd_src      = SRC_ZERO;
    dec_o.reg_sel     = reg_sel;
    unique case (op_e'(op_i))
      OP_READ: begin
        priority if (boot_window) begin
          dec_o.rd_src = boot_in_range ? SRC_BOOT : SRC_ZERO;
        end else if (reg_hit) begin
          dec_o.rd_src = SRC_REG;
        end else if (is_io) begin
          dec_o.rd_src = SRC_IO;
        end else begin
          dec_o.rd_src = SRC_MAIN;
        end
      end
      OP_WRITE: begin
        priority if (boot_en_i && (addr_i == ADDR_BOOT_OFF)) begin
          dec_o.boot_off = 1'b1;
        end else if (reg_hit) begin
          dec_o.reg_wr = 1'b1;
        end else if (is_io) begin
          dec_o.io_wr       = 1'b1;
          dec_o.div_clear   = (addr_i == ADDR_DIV);
          dec_o.io_byte     = dec_o.div_clear ? '0 : value_i;
          dec_o.latch_wr    = (addr_i == ADDR_SERIAL_DATA);
          dec_o.serial_fire = (addr_i == ADDR_SERIAL_CTRL) && value_i[SERIAL_START_BIT];
        end else begin
          dec_o.main_wr = 1'b1;
        end
      end
      OP_LOAD: begin
        dec_o.boot_wr = boot_in_range;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule
